// ===== rtl/core/assert_macros.svh =====
// assert_macros.svh
// Shared assertion shorthands for the flow meter checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in one cycle implies consequent in the next, quiet during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Same check, but also active while reset is asserted.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pfrm_pkg.sv =====
// ----------------------------------------------------------------------------
// pfrm_pkg
// Types and constants shared by the pulse flow rate meter files.
// ----------------------------------------------------------------------------
package pfrm_pkg;

  localparam int RATE_W     = 24;
  localparam int COUNT_W    = 16;
  localparam int DEBOUNCE_W = 8;
  localparam int TIMEOUT_W  = 16;
  localparam int REG_IDX_W  = 2;
  localparam int DIV_CNT_W  = $clog2(RATE_W);

  // Register indexes on the configuration channel
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RATE_K   = 2'd2;

  // Reset values of the registers
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 8'd10;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 16'd1000;
  localparam logic [RATE_W-1:0]     RATE_K_RST   = 24'd133333;

  typedef struct packed {
    logic time_tick;
    logic pulse_edge;
  } sample_t;

  typedef struct packed {
    logic [RATE_W-1:0]  flow_rate;
    logic [COUNT_W-1:0] pulse_count;
    logic               pulse_accepted;
  } report_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] reg_index;
    logic [RATE_W-1:0]    wdata;
  } cfg_wr_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } meter_state_t;

endpackage

// ===== rtl/core/pfrm_stream_if.sv =====
// ----------------------------------------------------------------------------
// pfrm_stream_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface pfrm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/pfrm_div.sv =====
// ----------------------------------------------------------------------------
// pfrm_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfrm_div
  import pfrm_pkg::*;
#(
  parameter int DIVISOR_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [RATE_W-1:0]       dividend,
  input  logic [DIVISOR_BITS-1:0] divisor,
  output logic [RATE_W-1:0]       quotient,
  output div_status_t             status
);

  logic [RATE_W-1:0]       dq;     // dividend shifts out, quotient shifts in
  logic [DIVISOR_BITS-1:0] rem;
  logic [DIVISOR_BITS-1:0] dsr;
  logic [DIV_CNT_W-1:0]    cnt;
  logic                    busy;
  logic                    done;
  logic [DIVISOR_BITS:0]   trial;

  // Trial subtract of the divisor from the partial remainder
  assign trial = {rem, dq[RATE_W-1]} - {1'b0, dsr};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(RATE_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[DIVISOR_BITS]) begin
        rem <= trial[DIVISOR_BITS-1:0];
        dq  <= {dq[RATE_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DIVISOR_BITS-2:0], dq[RATE_W-1]};
        dq  <= {dq[RATE_W-2:0], 1'b0};
      end
    end
  end

  assign quotient    = dq;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== rtl/core/pulse_flow_rate_meter_top.sv =====
// ----------------------------------------------------------------------------
// pulse_flow_rate_meter_top
// Pulse-period flow meter with debounce, timeout and serial rate division.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one request per millisecond slot, carrying time_tick and
//            pulse_edge. Exactly one report follows each request.
//   report : flow_rate (0.001 L/min), pulse_count, pulse_accepted.
//   cfg    : register writes (debounce_ms, timeout_ms, rate_constant),
//            always ready, to be issued only while the meter is idle.
// Sequencing:
//   A request without a new rate passes through ST_FIN to the report register.
//   An accepted pulse with a nonzero period runs the bit-serial divider,
//   one quotient bit per cycle, in ST_DIV before ST_FIN. One request is in work
//   at a time; a new one is taken as soon as the previous result sits in
//   the report register.
// Reset: synchronous; counters and held rate clear, registers take their
//   default values, no report is pending.
// Stall: a report waits in its register while report.ready is low; the
//   meter takes one more request, then holds it until the register frees.
// ----------------------------------------------------------------------------
module pulse_flow_rate_meter_top
  import pfrm_pkg::*;
#(
  parameter int ELAPSED_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  pfrm_stream_if.sink   cfg,
  pfrm_stream_if.sink   sample,
  pfrm_stream_if.source report
);

  localparam int CMP_W = (ELAPSED_BITS > TIMEOUT_W) ? ELAPSED_BITS : TIMEOUT_W;

  // Configuration registers
  logic [DEBOUNCE_W-1:0] debounce_ms;
  logic [TIMEOUT_W-1:0]  timeout_ms;
  logic [RATE_W-1:0]     rate_constant;

  // Meter state
  logic [ELAPSED_BITS-1:0] elapsed_ms;
  logic [COUNT_W-1:0]      pulse_total;
  logic [RATE_W-1:0]       held_rate;
  logic                    accepted;
  meter_state_t            state;
  meter_state_t            state_next;

  // Report register
  logic    report_valid;
  report_t report_data;

  logic                    take;
  logic                    div_start;
  logic                    load_report;
  logic                    edge_ok;
  logic [ELAPSED_BITS-1:0] elapsed_tick;
  logic [RATE_W-1:0]       quotient;
  logic [RATE_W-1:0]       rate_out;
  div_status_t             div_stat;

  // Configuration writes; unknown indexes are ignored
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms   <= DEBOUNCE_RST;
      timeout_ms    <= TIMEOUT_RST;
      rate_constant <= RATE_K_RST;
    end else if (cfg.valid) begin
      unique case (cfg.data.reg_index)
        REG_DEBOUNCE: debounce_ms   <= cfg.data.wdata[DEBOUNCE_W-1:0];
        REG_TIMEOUT:  timeout_ms    <= cfg.data.wdata[TIMEOUT_W-1:0];
        REG_RATE_K:   rate_constant <= cfg.data.wdata;
        default: ;
      endcase
    end
  end

  // Tick first (saturating), then debounce check on the advanced count
  always_comb begin
    elapsed_tick = elapsed_ms;
    if (sample.data.time_tick && (elapsed_ms != '1)) begin
      elapsed_tick = elapsed_ms + 1'b1;
    end
    edge_ok = sample.data.pulse_edge && (elapsed_tick >= ELAPSED_BITS'(debounce_ms));
  end

  assign sample.ready = (state == ST_IDLE);
  assign take         = sample.valid && (state == ST_IDLE);

  // Sequencer: next state and strobes
  always_comb begin
    state_next  = state;
    div_start   = 1'b0;
    load_report = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          if (edge_ok && (elapsed_tick != '0)) begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!report_valid || report.ready) begin
          load_report = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counters and held rate
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ms  <= '0;
      pulse_total <= '0;
      held_rate   <= '0;
      accepted    <= 1'b0;
    end else begin
      if (take) begin
        elapsed_ms <= edge_ok ? '0 : elapsed_tick;
        accepted   <= edge_ok;
        if (edge_ok) begin
          pulse_total <= pulse_total + 1'b1;
        end
      end
      if ((state == ST_DIV) && div_stat.done) begin
        held_rate <= quotient;
      end
    end
  end

  pfrm_div #(
    .DIVISOR_BITS(ELAPSED_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rate_constant),
    .divisor  (elapsed_tick),
    .quotient (quotient),
    .status   (div_stat)
  );

  // Reported rate drops to zero past the timeout
  assign rate_out = (CMP_W'(elapsed_ms) > CMP_W'(timeout_ms)) ? '0 : held_rate;

  // Report register
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (load_report) begin
      report_valid <= 1'b1;
    end else if (report.ready) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_report) begin
      report_data.flow_rate      <= rate_out;
      report_data.pulse_count    <= pulse_total;
      report_data.pulse_accepted <= accepted;
    end
  end

  assign report.valid = report_valid;
  assign report.data  = report_data;

endmodule

// ===== rtl/core/pfrm_checker.sv =====
// ----------------------------------------------------------------------------
// pfrm_checker
// Port-level checks for the flow meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfrm_checker
  import pfrm_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    sample_valid,
  input logic    sample_ready,
  input logic    report_valid,
  input logic    report_ready,
  input report_t report_data
);

  logic sample_take;
  logic report_stall;

  assign sample_take  = sample_valid && sample_ready;
  assign report_stall = report_valid && !report_ready;

  // Reset leaves no report pending
  `ASSERT_NEXT_ALWAYS(a_rst_no_report, clk, rst, !report_valid, "report valid after reset")

  // One request in work at a time
  `ASSERT_NEXT(a_one_in_work, clk, rst, sample_take, !sample_ready, "request taken while busy")

  // A stalled report stays and holds its payload
  `ASSERT_NEXT(a_stall_valid, clk, rst, report_stall, report_valid, "stalled report dropped")
  `ASSERT_NEXT(a_stall_data, clk, rst, report_stall, $stable(report_data), "stalled report changed")

endmodule

bind pulse_flow_rate_meter_top pfrm_checker u_pfrm_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample.valid),
  .sample_ready (sample.ready),
  .report_valid (report.valid),
  .report_ready (report.ready),
  .report_data  (report.data)
);
